// ===== sv/sat_pkg.sv =====
// Package for the ATA to SCSI pass-through block translator.
// Holds the status codes, protocol codes, item types and the command ROM lookup.
// No dependencies.
package sat_pkg;

	localparam int ROM_ROWS = 94;

	localparam logic [7:0] PT_OPCODE = 8'h85;
	localparam logic [3:0] P_NOD     = 4'h3;
	localparam logic [3:0] P_PIN     = 4'h4;
	localparam logic [3:0] P_POU     = 4'h5;
	localparam logic [3:0] P_DMA     = 4'h6;
	localparam logic [3:0] P_EXD     = 4'h8;
	localparam logic [3:0] P_NCQ     = 4'hC;
	localparam logic       BYT_BLK   = 1'b1;
	localparam logic [1:0] TLEN_CNT  = 2'd2;
	localparam logic [1:0] TLEN_FEAT = 2'd1;
	localparam logic [1:0] TLEN_NONE = 2'd0;
	localparam logic [4:0] LEN_28    = 5'd8;
	localparam logic [4:0] LEN_48    = 5'd12;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_LEN,
		ST_UNKNOWN,
		ST_FORM
	} sat_status_t;

	// ROM lookup result
	typedef struct packed {
		logic       hit;
		logic [6:0] idx;
		logic [3:0] proto;
		logic       queued;
		logic       wide;
	} rom_hit_t;

	// classified request, front to back
	typedef struct packed {
		sat_status_t status;
		logic [6:0]  idx;
		logic [3:0]  proto;
		logic        wide;
		logic [1:0]  tlen;
		logic        dir;
		logic [63:0] front;
		logic [31:0] back;
	} sat_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sat_qstat_t;

	function automatic rom_hit_t row(input logic [6:0] idx, input logic [3:0] proto,
			input logic queued, input logic wide);
		rom_hit_t r;
		r.hit    = 1'b1;
		r.idx    = idx;
		r.proto  = proto;
		r.queued = queued;
		r.wide   = wide;
		return r;
	endfunction

	// First matching ROM row. Rows sharing an opcode are contiguous and share
	// one form, so the sub-field picks the row directly.
	function automatic rom_hit_t rom_lookup(input logic [7:0] opc, input logic [15:0] feat_w,
			input logic [7:0] feat_n, input logic [3:0] cnt_hi_w);
		rom_hit_t r;
		r = '0;
		case (opc)
			8'hE5: r = row(7'd0,  P_NOD, 1'b0, 1'b0);
			8'h14: r = row(7'd1,  P_NOD, 1'b0, 1'b1);
			8'h51: r = row(7'd2,  P_NOD, 1'b0, 1'b1);
			8'h06: r = row(7'd3,  P_DMA, 1'b0, 1'b1);
			8'h07: r = row(7'd4,  P_DMA, 1'b0, 1'b1);
			8'h92: r = row(7'd5,  P_POU, 1'b0, 1'b0);
			8'h93: r = row(7'd6,  P_DMA, 1'b0, 1'b0);
			8'h90: r = row(7'd7,  P_EXD, 1'b0, 1'b0);
			8'hE7: r = row(7'd8,  P_NOD, 1'b0, 1'b0);
			8'hEA: r = row(7'd9,  P_NOD, 1'b0, 1'b1);
			8'h78: begin
				if (feat_w <= 16'd2)
					r = row(7'd10 + {5'b0, feat_w[1:0]}, P_NOD, 1'b0, 1'b1);
			end
			8'h12: r = row(7'd13, P_DMA, 1'b0, 1'b1);
			8'hEC: r = row(7'd14, P_PIN, 1'b0, 1'b0);
			8'hE3: r = row(7'd15, P_NOD, 1'b0, 1'b0);
			8'hE1: r = row(7'd16, P_NOD, 1'b0, 1'b0);
			8'h96: r = row(7'd17, P_NOD, 1'b0, 1'b1);
			8'h63: begin
				if (feat_w[3:0] <= 4'd8)
					r = row(7'd18 + {3'b0, feat_w[3:0]}, P_NOD, 1'b1, 1'b1);
			end
			8'h00: r = row(7'd27, P_NOD, 1'b0, 1'b0);
			8'hE4: r = row(7'd28, P_PIN, 1'b0, 1'b0);
			8'hE9: r = row(7'd29, P_DMA, 1'b0, 1'b0);
			8'hC8: r = row(7'd30, P_DMA, 1'b0, 1'b0);
			8'h25: r = row(7'd31, P_DMA, 1'b0, 1'b1);
			8'h60: r = row(7'd32, P_DMA, 1'b1, 1'b1);
			8'h47: r = row(7'd33, P_DMA, 1'b0, 1'b1);
			8'h2F: r = row(7'd34, P_PIN, 1'b0, 1'b1);
			8'h20: r = row(7'd35, P_PIN, 1'b0, 1'b0);
			8'h24: r = row(7'd36, P_PIN, 1'b0, 1'b1);
			8'h2A: r = row(7'd37, P_DMA, 1'b0, 1'b1);
			8'h2B: r = row(7'd38, P_PIN, 1'b0, 1'b1);
			8'h40: r = row(7'd39, P_NOD, 1'b0, 1'b0);
			8'h42: r = row(7'd40, P_NOD, 1'b0, 1'b1);
			8'h65: begin
				if (cnt_hi_w == 4'd1 || cnt_hi_w == 4'd2)
					r = row(7'd40 + {3'b0, cnt_hi_w}, P_DMA, 1'b1, 1'b1);
			end
			8'h7C: r = row(7'd43, P_NOD, 1'b0, 1'b1);
			8'h7E: r = row(7'd44, P_NOD, 1'b0, 1'b1);
			8'h0B: r = row(7'd45, P_NOD, 1'b0, 1'b1);
			8'h7D: r = row(7'd46, P_NOD, 1'b0, 1'b1);
			8'hB4: begin
				case (feat_w)
					16'h0000: r = row(7'd47, P_NOD, 1'b0, 1'b1);
					16'h0011: r = row(7'd48, P_NOD, 1'b0, 1'b1);
					16'h0012: r = row(7'd49, P_NOD, 1'b0, 1'b1);
					16'h0014: r = row(7'd50, P_NOD, 1'b0, 1'b1);
					16'h0020: r = row(7'd51, P_NOD, 1'b0, 1'b1);
					16'h0040: r = row(7'd52, P_NOD, 1'b0, 1'b1);
					default:  r = '0;
				endcase
			end
			8'hF6: r = row(7'd53, P_POU, 1'b0, 1'b0);
			8'hF3: r = row(7'd54, P_NOD, 1'b0, 1'b0);
			8'hF4: r = row(7'd55, P_POU, 1'b0, 1'b0);
			8'hF5: r = row(7'd56, P_NOD, 1'b0, 1'b0);
			8'hF1: r = row(7'd57, P_NOD, 1'b0, 1'b0);
			8'hF2: r = row(7'd58, P_NOD, 1'b0, 1'b0);
			8'h64: begin
				if (cnt_hi_w <= 4'd5)
					r = row(7'd59 + {3'b0, cnt_hi_w}, P_DMA, 1'b1, 1'b1);
			end
			8'h77: r = row(7'd65, P_NOD, 1'b0, 1'b1);
			8'hEF: r = row(7'd66, P_NOD, 1'b0, 1'b0);
			8'hB2: r = row(7'd67, P_NOD, 1'b0, 1'b1);
			8'hE6: r = row(7'd68, P_NOD, 1'b0, 1'b0);
			8'hB0: begin
				case (feat_n)
					8'hD5:   r = row(7'd69, P_PIN, 1'b0, 1'b0);
					8'hD6:   r = row(7'd70, P_POU, 1'b0, 1'b0);
					8'hDA:   r = row(7'd71, P_NOD, 1'b0, 1'b0);
					default: r = '0;
				endcase
			end
			8'hE2: r = row(7'd72, P_NOD, 1'b0, 1'b0);
			8'hE0: r = row(7'd73, P_NOD, 1'b0, 1'b0);
			8'h5B: r = row(7'd74, P_NOD, 1'b0, 1'b0);
			8'h5C: r = row(7'd75, P_PIN, 1'b0, 1'b0);
			8'h5D: r = row(7'd76, P_DMA, 1'b0, 1'b0);
			8'h5E: r = row(7'd77, P_NOD, 1'b0, 1'b0);
			8'h5F: r = row(7'd78, P_DMA, 1'b0, 1'b0);
			8'hE8: r = row(7'd79, P_POU, 1'b0, 1'b0);
			8'hEB: r = row(7'd80, P_DMA, 1'b0, 1'b0);
			8'hCA: r = row(7'd81, P_DMA, 1'b0, 1'b0);
			8'h35: r = row(7'd82, P_DMA, 1'b0, 1'b1);
			8'h3D: r = row(7'd83, P_DMA, 1'b0, 1'b1);
			8'h61: r = row(7'd84, P_DMA, 1'b1, 1'b1);
			8'h66: r = row(7'd85, P_DMA, 1'b0, 1'b1);
			8'h57: r = row(7'd86, P_DMA, 1'b0, 1'b1);
			8'h3F: r = row(7'd87, P_POU, 1'b0, 1'b1);
			8'h30: r = row(7'd88, P_POU, 1'b0, 1'b0);
			8'h34: r = row(7'd89, P_POU, 1'b0, 1'b1);
			8'h3A: r = row(7'd90, P_DMA, 1'b0, 1'b1);
			8'h3B: r = row(7'd91, P_POU, 1'b0, 1'b1);
			8'h45: r = row(7'd92, P_NOD, 1'b0, 1'b1);
			8'h44: r = row(7'd93, P_NOD, 1'b0, 1'b1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/sat_if.sv =====
// Channel interfaces of the pass-through translator: ATA request in, CDB out.
// Valid/ready handshake, payload carried with valid. No dependencies.
interface sat_cmd_if;
	logic        valid;
	logic        ready;
	logic [63:0] cmd_bytes_front;
	logic [31:0] cmd_bytes_back;
	logic [4:0]  block_length;
	logic        has_buffer;
	logic        from_device;

	modport source (output valid, cmd_bytes_front, cmd_bytes_back, block_length,
		has_buffer, from_device, input ready);
	modport sink (input valid, cmd_bytes_front, cmd_bytes_back, block_length,
		has_buffer, from_device, output ready);
endinterface

interface sat_pass_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] pass_bytes_front;
	logic [63:0] pass_bytes_back;
	logic [6:0]  entry_index;

	modport source (output valid, status, pass_bytes_front, pass_bytes_back, entry_index,
		input ready);
	modport sink (input valid, status, pass_bytes_front, pass_bytes_back, entry_index,
		output ready);
endinterface

// ===== sv/sat_front.sv =====
// Front end: accepts ATA requests, checks length, looks up the command ROM.
// Depends on sat_pkg and sat_cmd_if.
module sat_front (
	sat_cmd_if.sink           cmd,
	input  sat_pkg::sat_qstat_t q_stat,
	output logic              push,
	output sat_pkg::sat_item_t push_item
);
	import sat_pkg::*;

	logic [7:0] b [12];
	logic       len8;
	logic       len12;
	logic [7:0] opc;
	rom_hit_t   lk;

	always_comb begin
		for (int i = 0; i < 8; i++)
			b[i] = cmd.cmd_bytes_front[63 - 8 * i -: 8];
		for (int i = 0; i < 4; i++)
			b[8 + i] = cmd.cmd_bytes_back[31 - 8 * i -: 8];
	end

	assign len8  = (cmd.block_length == LEN_28);
	assign len12 = (cmd.block_length == LEN_48);
	// opcode is the last byte of the block
	assign opc   = len12 ? b[11] : b[7];
	// wide rows read feature as bytes 0:1 and the count sub-field from the low nibble of byte 2
	assign lk    = rom_lookup(opc, {b[0], b[1]}, b[0], b[2][3:0]);

	assign cmd.ready = !q_stat.full;
	assign push      = cmd.valid && !q_stat.full;

	always_comb begin
		push_item.front = cmd.cmd_bytes_front;
		push_item.back  = cmd.cmd_bytes_back;
		push_item.dir   = cmd.from_device;
		push_item.wide  = lk.wide;
		push_item.proto = lk.queued ? P_NCQ : lk.proto;
		if (!cmd.has_buffer)
			push_item.tlen = TLEN_NONE;
		else
			push_item.tlen = lk.queued ? TLEN_FEAT : TLEN_CNT;
		if (!(len8 || len12)) begin
			push_item.status = ST_BAD_LEN;
			push_item.idx    = '0;
		end else if (!lk.hit) begin
			push_item.status = ST_UNKNOWN;
			push_item.idx    = '0;
		end else if (lk.wide != len12) begin
			push_item.status = ST_FORM;
			push_item.idx    = lk.idx;
		end else begin
			push_item.status = ST_OK;
			push_item.idx    = lk.idx;
		end
	end
endmodule

// ===== sv/sat_queue.sv =====
// Small FIFO between the classifying front end and the CDB builder.
// Depends on sat_pkg.
module sat_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sat_pkg::sat_item_t push_item,
	input  logic               pop,
	output sat_pkg::sat_item_t head_item,
	output sat_pkg::sat_qstat_t stat
);
	import sat_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sat_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

// ===== sv/sat_back.sv =====
// Back end: builds the 16-byte ATA PASS-THROUGH(16) CDB into the output register.
// Depends on sat_pkg and sat_pass_if.
module sat_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sat_pkg::sat_item_t head_item,
	input  sat_pkg::sat_qstat_t q_stat,
	output logic               pop,
	sat_pass_if.source         pass
);
	import sat_pkg::*;

	logic [7:0]  b [12];
	logic [7:0]  p [16];
	logic [63:0] pf;
	logic [63:0] pb;
	logic        valid_q;
	sat_status_t status_q;
	logic [63:0] front_q;
	logic [63:0] back_q;
	logic [6:0]  idx_q;

	always_comb begin
		for (int i = 0; i < 8; i++)
			b[i] = head_item.front[63 - 8 * i -: 8];
		for (int i = 0; i < 4; i++)
			b[8 + i] = head_item.back[31 - 8 * i -: 8];
	end

	always_comb begin
		for (int i = 0; i < 16; i++)
			p[i] = '0;
		p[0] = PT_OPCODE;
		p[1] = {3'b0, head_item.proto, head_item.wide};
		p[2] = {4'b0, head_item.dir, BYT_BLK, head_item.tlen};
		if (head_item.wide) begin
			// LBA shuffle of the 48-bit form
			p[3]  = b[0];
			p[4]  = b[1];
			p[5]  = b[2];
			p[6]  = b[3];
			p[7]  = b[6];
			p[8]  = b[9];
			p[9]  = b[5];
			p[10] = b[8];
			p[11] = b[4];
			p[12] = b[7];
			p[13] = b[10];
			p[14] = b[11];
		end else begin
			p[4]  = b[0];
			p[6]  = b[1];
			p[7]  = {4'b0, b[2][3:0]};
			p[8]  = b[5];
			p[10] = b[4];
			p[12] = b[3];
			p[13] = b[6];
			p[14] = b[7];
		end
		for (int i = 0; i < 8; i++) begin
			pf[63 - 8 * i -: 8] = p[i];
			pb[63 - 8 * i -: 8] = p[8 + i];
		end
	end

	assign pop = !q_stat.empty && (!valid_q || pass.ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= head_item.status;
			idx_q    <= head_item.idx;
			front_q  <= (head_item.status == ST_OK) ? pf : '0;
			back_q   <= (head_item.status == ST_OK) ? pb : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (pop)
				valid_q <= 1'b1;
			else if (pass.ready)
				valid_q <= 1'b0;
		end
	end

	assign pass.valid            = valid_q;
	assign pass.status           = status_q;
	assign pass.pass_bytes_front = front_q;
	assign pass.pass_bytes_back  = back_q;
	assign pass.entry_index      = idx_q;
endmodule

// ===== sv/ata_to_scsi_passthrough_cdb_top.sv =====
// Top level of the ATA to SCSI ATA PASS-THROUGH(16) CDB translator.
// Depends on sat_pkg, sat_if, sat_front, sat_queue and sat_back.
//
// Usage:
//   cmd  : ATA request in (8- or 12-byte block, buffer flag, direction).
//   pass : one result per request: status, the 16-byte CDB, matched ROM row.
//   A request is taken on a clock edge with valid and ready high.
// Throughput: one request per cycle, sustained while pass.ready stays high. The front
//   end classifies a request against the command ROM in the cycle it is taken; the
//   back end builds the CDB from the queue head into the output register.
// Path: the request is queued at the edge that takes it; the back end then moves it
//   from the queue head into the output register, where it can be taken.
// Stall: the queue of QUEUE_DEPTH entries plus the output register hold
//   pending results; cmd.ready drops only when the queue is full, and a
//   stalled result holds steady until taken.
// Reset: arst_n empties the queue and the output register; the block has no
//   other state and can take a request as soon as reset is released.
module ata_to_scsi_passthrough_cdb_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic      clk,
	input logic      arst_n,
	sat_cmd_if.sink  cmd,
	sat_pass_if.source pass
);
	import sat_pkg::*;

	logic       push;
	logic       pop;
	sat_item_t  push_item;
	sat_item_t  head_item;
	sat_qstat_t q_stat;

	sat_front u_front (
		.cmd       (cmd),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	sat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	sat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_stat    (q_stat),
		.pop       (pop),
		.pass      (pass)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pass.valid && pass.status != ST_OK) |->
		(pass.pass_bytes_front == '0 && pass.pass_bytes_back == '0))
		else $error("error result carries nonzero CDB bytes");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pass.valid && (pass.status == ST_BAD_LEN || pass.status == ST_UNKNOWN)) |->
		(pass.entry_index == '0))
		else $error("unmatched request reports a ROM row");

	a_ok_head: assert property (@(posedge clk) disable iff (!arst_n)
		(pass.valid && pass.status == ST_OK) |->
		(pass.pass_bytes_front[63:56] == PT_OPCODE && pass.pass_bytes_front[42] == BYT_BLK))
		else $error("good result lacks pass-through opcode or byt_blk");
endmodule
